// ----- rtl/taylor_sin_cos_tan_series_defines.svh -----
// Assertion macros for the Taylor series sine, cosine and tangent block.
`ifndef TAYLOR_SIN_COS_TAN_SERIES_DEFINES_SVH
`define TAYLOR_SIN_COS_TAN_SERIES_DEFINES_SVH
`ifndef SYNTHESIS
`define TSCT_ASSERT_IMPL(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("implication check failed");
`define TSCT_ASSERT_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("next-cycle check failed");
`else
`define TSCT_ASSERT_IMPL(label, clk, rstn, a, c)
`define TSCT_ASSERT_NEXT(label, clk, rstn, a, c)
`endif
`endif

// ----- rtl/tsct_pkg.sv -----
// Shared constants, types and functions for the Taylor series block.
package tsct_pkg;
    localparam int MAX_TERMS = 32;
    localparam int ANGLE_FRAC_BITS = 28;
    localparam logic [31:0] ANGLE_LIMIT = 32'd843314856;
    localparam logic [39:0] TERM_ONE = 40'h04_0000_0000;
    localparam logic [47:0] TERM_MAX = 48'h00_7F_FFFF_FFFF;
    localparam logic [26:0] THRESH_RESET = 27'd67;
    localparam logic [26:0] SUM_ONE = 27'h400_0000;

    typedef struct packed {
        logic load_inv;
        logic init;
        logic mul_hi;
        logic mul_lo;
        logic div_term;
        logic term_load;
        logic accum;
        logic div_tan;
        logic res_load;
        logic next_row;
    } cmd_t;

    typedef struct packed {
        logic angle_bad;
        logic div_done;
        logic fin;
    } sts_t;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
        else if (v < -34'sh0_8000_0000) r = 32'sh8000_0000;
        else r = v[31:0];
        return r;
    endfunction
endpackage

// ----- rtl/taylor_sin_cos_tan_series.sv -----
// First row: accumulate, tangent division and result load after the angle is taken.
// Each later row runs two multiply steps and two passes of one shared divider.
// An angle gives up to 32 rows; an invalid angle gives a single word.
// A new angle is taken only after the final word of the previous one is delivered.
// Reset is synchronous, active low, and restores the threshold to 67.
`include "taylor_sin_cos_tan_series_defines.svh"
module taylor_sin_cos_tan_series import tsct_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // angle
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // term_count, sine_value, cosine_value, tangent_value, pad
    output logic [1:0]   m_tuser,   // invalid_angle, cap_reached
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [26:0]  cfg_data
);
    cmd_t cmd;
    sts_t sts;
    logic in_bad;

    assign cfg_ready = 1'b1;
    assign in_bad = sts.angle_bad;

    tsct_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .sts({s_tready ? in_bad : m_tuser[0], sts.div_done, sts.fin}), .cmd(cmd)
    );

    tsct_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts), .angle(s_tdata),
        .cfg_valid(cfg_valid), .cfg_data(cfg_data),
        .out_data(m_tdata), .out_user(m_tuser), .out_last(m_tlast)
    );

    `TSCT_ASSERT_IMPL(a_inv_last, aclk, aresetn, m_tvalid && m_tuser[0], m_tlast)
    `TSCT_ASSERT_IMPL(a_one_item, aclk, aresetn, s_tready, !m_tvalid)
    `TSCT_ASSERT_IMPL(a_cap_row, aclk, aresetn, m_tvalid && m_tuser[1],
        m_tlast && (m_tdata[5:0] == 6'(MAX_TERMS)))
endmodule

// ----- rtl/tsct_div.sv -----
// Restoring divider, one quotient bit per cycle.
module tsct_div import tsct_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [47:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [47:0] quotient
);
    logic [31:0] rem_reg, rem_next;
    logic [47:0] quo_reg, quo_next;
    logic [31:0] div_reg;
    logic [5:0] cnt_reg;
    logic busy_reg, done_reg;
    logic [32:0] trial;

    always_comb begin
        trial = {rem_reg, quo_reg[47]};
        if (trial >= {1'b0, div_reg}) begin
            rem_next = 32'(trial - {1'b0, div_reg});
            quo_next = {quo_reg[46:0], 1'b1};
        end else begin
            rem_next = trial[31:0];
            quo_next = {quo_reg[46:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd47) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done = done_reg;
    assign quotient = quo_reg;
endmodule

// ----- rtl/tsct_datapath.sv -----
// Datapath: term recurrence, partial sums, convergence test and tangent.
module tsct_datapath import tsct_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  cmd_t         cmd,
    output sts_t         sts,
    input  logic [31:0]  angle,
    input  logic         cfg_valid,
    input  logic [26:0]  cfg_data,
    output logic [103:0] out_data,
    output logic [1:0]   out_user,
    output logic         out_last
);
    logic [26:0] thr_reg;
    logic signed [31:0] angle_reg;
    logic [29:0] mx_reg;
    logic signed [39:0] term_reg;
    logic [5:0] n_reg;
    logic signed [31:0] sin_reg, cos_reg;
    logic conv_reg, fin_reg;
    logic [37:0] prod_hi_reg;
    logic [62:0] prod_lo_reg;
    logic [5:0] k;
    logic [39:0] mt;
    logic [32:0] contrib;
    logic signed [33:0] s_ext, c_ext, ctr_ext;
    logic signed [31:0] s_new, c_new;
    logic [33:0] ds, dc;
    logic conv;
    logic [31:0] abs_angle, ms, mc;
    logic div_start, div_done;
    logic [47:0] div_dvd, quo, pval, qc;
    logic [31:0] div_dvs;
    logic signed [31:0] tan;

    assign abs_angle = angle[31] ? 32'(-angle) : angle;
    assign sts.angle_bad = abs_angle > ANGLE_LIMIT;
    assign sts.div_done = div_done;
    assign sts.fin = fin_reg;

    assign k = n_reg - 6'd1;
    assign mt = term_reg[39] ? 40'(-term_reg) : term_reg;
    assign contrib = 33'((41'(mt) + 41'd128) >> 8);
    assign ctr_ext = term_reg[39] ? -34'(contrib) : 34'(contrib);
    assign s_ext = 34'(sin_reg);
    assign c_ext = 34'(cos_reg);

    always_comb begin
        s_new = sin_reg;
        c_new = cos_reg;
        case (k[1:0])
            2'd0: c_new = sat32(c_ext + ctr_ext);
            2'd1: s_new = sat32(s_ext + ctr_ext);
            2'd2: c_new = sat32(c_ext - ctr_ext);
            default: s_new = sat32(s_ext - ctr_ext);
        endcase
    end

    always_comb begin
        logic signed [33:0] d1, d2;
        d1 = 34'(s_new) - s_ext;
        d2 = 34'(c_new) - c_ext;
        ds = d1[33] ? 34'(-d1) : d1;
        dc = d2[33] ? 34'(-d2) : d2;
        if (n_reg == 6'd1) conv = SUM_ONE <= thr_reg;
        else conv = (ds <= 34'(thr_reg)) && (dc <= 34'(thr_reg));
    end

    assign pval = 48'({prod_hi_reg, 4'b0}) + 48'(prod_lo_reg >> ANGLE_FRAC_BITS)
                  + 48'(k >> 1);
    assign ms = sin_reg[31] ? 32'(-sin_reg) : sin_reg;
    assign mc = cos_reg[31] ? 32'(-cos_reg) : cos_reg;
    assign div_start = cmd.div_term | cmd.div_tan;
    assign div_dvd = cmd.div_term ? pval : {ms, 16'b0};
    assign div_dvs = cmd.div_term ? 32'(k) : mc;
    assign qc = (quo > TERM_MAX) ? TERM_MAX : quo;

    always_comb begin
        if (cos_reg == 32'sd0) begin
            if (sin_reg > 32'sd0) tan = 32'sh7FFF_FFFF;
            else if (sin_reg < 32'sd0) tan = 32'sh8000_0000;
            else tan = 32'sd0;
        end else if (sin_reg[31] != cos_reg[31]) begin
            tan = (quo > 48'h8000_0000) ? 32'sh8000_0000 : 32'(-quo);
        end else begin
            tan = (quo > 48'h7FFF_FFFF) ? 32'sh7FFF_FFFF : quo[31:0];
        end
    end

    tsct_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(div_dvd), .divisor(div_dvs), .done(div_done), .quotient(quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THRESH_RESET;
        end else if (cfg_valid) begin
            thr_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.init) begin
            angle_reg <= angle;
            mx_reg <= abs_angle[29:0];
            term_reg <= TERM_ONE;
            n_reg <= 6'd1;
            sin_reg <= '0;
            cos_reg <= '0;
        end
        if (cmd.mul_hi) prod_hi_reg <= 38'({1'b0, mt[39:32]} * mx_reg);
        if (cmd.mul_lo) prod_lo_reg <= 63'(mt[31:0] * mx_reg) + 63'h800_0000;
        if (cmd.term_load)
            term_reg <= (term_reg[39] ^ angle_reg[31]) ? 40'(-qc) : qc[39:0];
        if (cmd.accum) begin
            sin_reg <= s_new;
            cos_reg <= c_new;
            conv_reg <= conv;
            fin_reg <= conv || (n_reg == 6'(MAX_TERMS));
        end
        if (cmd.next_row) n_reg <= n_reg + 6'd1;
        if (cmd.res_load) begin
            out_data <= {2'b0, tan, cos_reg, sin_reg, n_reg};
            out_user <= {!conv_reg && (n_reg == 6'(MAX_TERMS)), 1'b0};
            out_last <= fin_reg;
        end
        if (cmd.load_inv) begin
            out_data <= '0;
            out_user <= 2'b01;
            out_last <= 1'b1;
        end
    end
endmodule

// ----- rtl/tsct_ctrl.sv -----
// Controller state machine sequencing one angle through its rows.
module tsct_ctrl import tsct_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    input  sts_t sts,
    output cmd_t cmd
);
    localparam logic [3:0] ST_IDLE = 4'd0, ST_MULH = 4'd1, ST_MULL = 4'd2,
        ST_DIVT = 4'd3, ST_DIVT_WAIT = 4'd4, ST_ACC = 4'd5, ST_TAN = 4'd6,
        ST_TAN_WAIT = 4'd7, ST_RES = 4'd8, ST_OUT = 4'd9;

    logic [3:0] state_reg, state_next;

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = state_reg == ST_OUT;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (sts.angle_bad) begin
                        cmd.load_inv = 1'b1;
                        state_next = ST_OUT;
                    end else begin
                        cmd.init = 1'b1;
                        state_next = ST_ACC;
                    end
                end
            end
            ST_MULH: begin
                cmd.mul_hi = 1'b1;
                state_next = ST_MULL;
            end
            ST_MULL: begin
                cmd.mul_lo = 1'b1;
                state_next = ST_DIVT;
            end
            ST_DIVT: begin
                cmd.div_term = 1'b1;
                state_next = ST_DIVT_WAIT;
            end
            ST_DIVT_WAIT: begin
                if (sts.div_done) begin
                    cmd.term_load = 1'b1;
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                cmd.accum = 1'b1;
                state_next = ST_TAN;
            end
            ST_TAN: begin
                cmd.div_tan = 1'b1;
                state_next = ST_TAN_WAIT;
            end
            ST_TAN_WAIT: begin
                if (sts.div_done) state_next = ST_RES;
            end
            ST_RES: begin
                cmd.res_load = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    if (sts.fin || sts.angle_bad) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.next_row = 1'b1;
                        state_next = ST_MULH;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the Taylor series sine, cosine and tangent block.
`timescale 1ns / 100ps
module tb_top;
    import tsct_pkg::*;

    typedef struct packed {
        logic [5:0]         term_count;
        logic signed [31:0] sine_value;
        logic signed [31:0] cosine_value;
        logic signed [31:0] tangent_value;
        logic               invalid_angle;
        logic               cap_reached;
        logic               last;
    } row_t;

    localparam int STALL_LIMIT = 40000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [31:0]  s_tdata;   // angle
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;   // term_count, sine_value, cosine_value, tangent_value, pad
    logic [1:0]   m_tuser;   // invalid_angle, cap_reached
    logic         m_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [26:0]  cfg_data;

    row_t         expected_rows[$];
    logic [26:0]  threshold;
    int           error_count;
    int           rows_checked;
    int           angles_sent;
    int           invalid_seen;
    int           caps_seen;
    int           idle_cycles;
    int           stall_pct;

    taylor_sin_cos_tan_series i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [63:0] magnitude(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic signed [63:0] next_term(input logic signed [63:0] t,
                                                     input logic signed [63:0] x,
                                                     input int k);
        logic        neg;
        logic [79:0] prod;
        logic [63:0] q;
        neg = (t < 0) != (x < 0);
        prod = ({16'd0, magnitude(t)} * {16'd0, magnitude(x)} + (80'd1 << 27)) >> 28;
        q = (prod[63:0] + 64'(k / 2)) / 64'(k);
        if (q > 64'h7F_FFFF_FFFF) q = 64'h7F_FFFF_FFFF;
        return neg ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [31:0] tangent_of(input logic signed [63:0] s,
                                                      input logic signed [63:0] c);
        logic [63:0] q;
        if (c == 0) return s > 0 ? 32'sh7FFF_FFFF : (s < 0 ? 32'sh8000_0000 : 32'sd0);
        q = (magnitude(s) << 16) / magnitude(c);
        if ((s < 0) != (c < 0))
            return q > 64'h8000_0000 ? 32'sh8000_0000 : 32'(-$signed(q));
        return q > 64'h7FFF_FFFF ? 32'sh7FFF_FFFF : 32'(q);
    endfunction

    task automatic predict_series(input logic signed [31:0] ang);
        logic signed [63:0] x, term, contrib, sine, cosine, prev_s, prev_c;
        logic [63:0]        ds, dc;
        logic               conv, fin;
        row_t               r;
        if (ang > $signed(ANGLE_LIMIT) || ang < -$signed(ANGLE_LIMIT)) begin
            expected_rows.push_back('{6'd0, 32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b0, 1'b1});
            return;
        end
        x = ang;
        term = 64'sd1 <<< 34;
        sine = 0;
        cosine = 0;
        prev_s = 0;
        prev_c = 0;
        for (int n = 1; n <= MAX_TERMS; n++) begin
            if (n > 1) term = next_term(term, x, n - 1);
            contrib = $signed((magnitude(term) + 64'd128) >> 8);
            if (term < 0) contrib = -contrib;
            case ((n - 1) % 4)
                0: cosine = clamp32(cosine + contrib);
                1: sine = clamp32(sine + contrib);
                2: cosine = clamp32(cosine - contrib);
                default: sine = clamp32(sine - contrib);
            endcase
            if (n == 1) begin
                ds = 64'd1 << 26;
                dc = 64'd1 << 26;
            end else begin
                ds = magnitude(sine - prev_s);
                dc = magnitude(cosine - prev_c);
            end
            conv = ds <= threshold && dc <= threshold;
            fin = conv || n == MAX_TERMS;
            r.term_count = 6'(n);
            r.sine_value = sine[31:0];
            r.cosine_value = cosine[31:0];
            r.tangent_value = tangent_of(sine, cosine);
            r.invalid_angle = 1'b0;
            r.cap_reached = !conv && n == MAX_TERMS;
            r.last = fin;
            expected_rows.push_back(r);
            prev_s = sine;
            prev_c = cosine;
            if (fin) break;
        end
    endtask

    task automatic send_angle(input logic [31:0] ang, input int gap);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= ang;
        do @(posedge aclk); while (!s_tready);
        predict_series(ang);
        angles_sent++;
    endtask

    task automatic write_threshold(input logic [26:0] value);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (expected_rows.size() == 0);
        repeat (20) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        threshold = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int count);
        int burst;
        int gap;
        logic [31:0] ang;
        burst = 0;
        for (int i = 0; i < count; i++) begin
            gap = 0;
            if (burst == 0) begin
                burst = $urandom_range(1, 6);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
            burst--;
            if ($urandom_range(0, 9) == 0)
                ang = $urandom;
            else
                ang = 32'($signed($urandom_range(0, 2 * ANGLE_LIMIT)) - $signed(ANGLE_LIMIT));
            send_angle(ang, gap);
        end
    endtask

    // Receiver back-pressure changes its character at random times.
    initial begin
        m_tready = 1'b0;
        stall_pct = 0;
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 299) == 0)
                stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 90);
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        row_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.term_count = m_tdata[5:0];
            got.sine_value = m_tdata[37:6];
            got.cosine_value = m_tdata[69:38];
            got.tangent_value = m_tdata[101:70];
            got.invalid_angle = m_tuser[0];
            got.cap_reached = m_tuser[1];
            got.last = m_tlast;
            if (expected_rows.size() == 0) begin
                $error("unexpected result word: term_count %0d", got.term_count);
                error_count++;
            end else begin
                want = expected_rows.pop_front();
                rows_checked++;
                if (got.invalid_angle) invalid_seen++;
                if (got.cap_reached) caps_seen++;
                if (got.term_count !== want.term_count) begin
                    $error("term_count: expected %0d, got %0d", want.term_count, got.term_count);
                    error_count++;
                end
                if (got.sine_value !== want.sine_value) begin
                    $error("sine_value: expected %0d, got %0d", want.sine_value, got.sine_value);
                    error_count++;
                end
                if (got.cosine_value !== want.cosine_value) begin
                    $error("cosine_value: expected %0d, got %0d",
                           want.cosine_value, got.cosine_value);
                    error_count++;
                end
                if (got.tangent_value !== want.tangent_value) begin
                    $error("tangent_value: expected %0d, got %0d",
                           want.tangent_value, got.tangent_value);
                    error_count++;
                end
                if (got.invalid_angle !== want.invalid_angle) begin
                    $error("invalid_angle: expected %0b, got %0b",
                           want.invalid_angle, got.invalid_angle);
                    error_count++;
                end
                if (got.cap_reached !== want.cap_reached) begin
                    $error("cap_reached: expected %0b, got %0b",
                           want.cap_reached, got.cap_reached);
                    error_count++;
                end
                if (got.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, got.last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired with %0d words outstanding.", expected_rows.size());
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [31:0] directed_angles[$];
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        threshold = THRESH_RESET;
        error_count = 0;
        rows_checked = 0;
        angles_sent = 0;
        invalid_seen = 0;
        caps_seen = 0;
        idle_cycles = 0;
        directed_angles = '{32'd0, ANGLE_LIMIT, -ANGLE_LIMIT, ANGLE_LIMIT + 32'd1,
                            -ANGLE_LIMIT - 32'd1, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'd1, 32'hFFFF_FFFF, 32'h1000_0000, 32'hF000_0000,
                            32'h1921_FB54, 32'hE6DE_04AC, 32'h0000_8000};
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed angles in turn; out-of-range ones must give one all-zero word flagged invalid.
        foreach (directed_angles[i]) begin
            if ($signed(directed_angles[i]) > $signed(ANGLE_LIMIT)
                    || $signed(directed_angles[i]) < -$signed(ANGLE_LIMIT)) begin
                send_angle(directed_angles[i], i % 3);
                void'(expected_rows.pop_back());
                expected_rows.push_back('{6'd0, 32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b0, 1'b1});
            end else begin
                send_angle(directed_angles[i], i % 3);
            end
        end
        random_phase(70);
        write_threshold(27'd0);
        foreach (directed_angles[i]) send_angle(directed_angles[i], 0);
        random_phase(50);
        write_threshold(27'd67108864);
        foreach (directed_angles[i]) send_angle(directed_angles[i], 1);
        random_phase(70);
        write_threshold(27'h7FF_FFFF);
        random_phase(20);
        write_threshold(27'(1 << $urandom_range(4, 22)));
        random_phase(70);
        write_threshold(27'($urandom_range(1, 5000)));
        random_phase(50);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (expected_rows.size() == 0);
        repeat (200) @(posedge aclk);
        $display("Sent %0d angles under six threshold settings; checked %0d words,",
                 angles_sent, rows_checked);
        $display("of which %0d were out-of-range angles and %0d hit the term cap.",
                 invalid_seen, caps_seen);
        if (error_count == 0 && expected_rows.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/tsct_pkg.sv
rtl/tsct_div.sv
rtl/tsct_datapath.sv
rtl/tsct_ctrl.sv
rtl/taylor_sin_cos_tan_series.sv
tb/tb_top.sv
